[rtl/frustum_plane_cull_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros of the frustum plane culling RTL.
// ---------------------------------------------------------------------------
`ifndef FRUSTUM_PLANE_CULL_MACROS_SVH
`define FRUSTUM_PLANE_CULL_MACROS_SVH

// Same-cycle implication.
`define FPC_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("frustum_plane_cull: assertion failed");

// Next-cycle implication.
`define FPC_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("frustum_plane_cull: assertion failed");

`endif

[rtl/fpc_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fpc_pkg
// Shared constants, codes and types of the frustum plane culling block.
// ---------------------------------------------------------------------------
package fpc_pkg;

   localparam int DEF_COORD_WIDTH = 32;
   localparam int DEF_FRAC_BITS   = 16;

   localparam int NUM_PLANES = 6;
   localparam int IN_WIDTH   = 32;

   // request kinds
   localparam logic [1:0] MODE_LOAD   = 2'd0;
   localparam logic [1:0] MODE_BUILD  = 2'd1;
   localparam logic [1:0] MODE_SPHERE = 2'd2;
   localparam logic [1:0] MODE_BOX    = 2'd3;

   // register indexes
   localparam logic [1:0] CSR_VIEW_MODE = 2'd0;
   localparam logic [1:0] CSR_NEAR_DIST = 2'd1;
   localparam logic [1:0] CSR_FAR_DIST  = 2'd2;

   localparam logic [2:0] REJ_NONE = 3'd6;

   typedef struct packed {
      logic busy;
      logic done;
      logic len_zero;
   } rd_status_type;

endpackage

[rtl/fpc_plane_cell.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fpc_plane_cell
// One plane (x, y, z, w) of the plane chain; takes its neighbor's plane on shift.
// ---------------------------------------------------------------------------
module fpc_plane_cell
   import fpc_pkg::*;
#(
   parameter int COORD_WIDTH = DEF_COORD_WIDTH
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        shift_en,
   input  logic [3:0][COORD_WIDTH-1:0] plane_in,
   output logic [3:0][COORD_WIDTH-1:0] plane_out
);

   logic [3:0][COORD_WIDTH-1:0] plane_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         plane_ff <= '0;
      end else if (shift_en) begin
         plane_ff <= plane_in;
      end
   end

   assign plane_out = plane_ff;

endmodule

[rtl/fpc_fmul.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fpc_fmul
// Shared two-stage fixed-point multiplier: raw magnitude product, then
// shift by the fraction bits with saturation and sign.
// ---------------------------------------------------------------------------
module fpc_fmul
   import fpc_pkg::*;
#(
   parameter int COORD_WIDTH = DEF_COORD_WIDTH,
   parameter int FRAC_BITS   = DEF_FRAC_BITS
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            issue,
   input  logic [COORD_WIDTH-1:0]          op_a,
   input  logic [COORD_WIDTH-1:0]          op_b,
   output logic                            raw_valid,
   output logic [2*COORD_WIDTH-1:0]        raw_prod,
   output logic                            res_valid,
   output logic [COORD_WIDTH-1:0]          res
);

   localparam int CW = COORD_WIDTH;
   localparam int PW = 2 * COORD_WIDTH;
   localparam logic [CW-1:0] MAXV = {1'b0, {(CW-1){1'b1}}};
   localparam logic [CW-1:0] MINV = {1'b1, {(CW-1){1'b0}}};

   logic [CW-1:0] mag_a, mag_b;
   logic [PW-1:0] prod_ff;
   logic          neg_ff, v1_ff, v2_ff;
   logic [CW-1:0] res_ff, res_in, lim, r;
   logic [PW-1:0] sh_w;

   assign mag_a = op_a[CW-1] ? (~op_a + 1'b1) : op_a;
   assign mag_b = op_b[CW-1] ? (~op_b + 1'b1) : op_b;

   always_comb begin
      sh_w   = prod_ff >> FRAC_BITS;
      lim    = neg_ff ? MINV : MAXV;
      r      = (sh_w > PW'(lim)) ? lim : sh_w[CW-1:0];
      res_in = neg_ff ? (~r + 1'b1) : r;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= issue;
         v2_ff <= v1_ff;
      end
      prod_ff <= PW'(mag_a) * PW'(mag_b);
      neg_ff  <= op_a[CW-1] ^ op_b[CW-1];
      res_ff  <= res_in;
   end

   assign raw_valid = v1_ff;
   assign raw_prod  = prod_ff;
   assign res_valid = v2_ff;
   assign res       = res_ff;

endmodule

[rtl/fpc_root_div.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fpc_root_div
// Inverse normal length: bit-serial integer square root of the square sum,
// then restoring division of 2^(2*FRAC_BITS) by the root, one bit a cycle.
// ---------------------------------------------------------------------------
module fpc_root_div
   import fpc_pkg::*;
#(
   parameter int COORD_WIDTH = DEF_COORD_WIDTH,
   parameter int FRAC_BITS   = DEF_FRAC_BITS
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [2*COORD_WIDTH-1:0]   radicand,
   output rd_status_type              status,
   output logic [COORD_WIDTH-1:0]     inv
);

   localparam int CW   = COORD_WIDTH;
   localparam int QW   = 2 * FRAC_BITS + 1;
   localparam int LW   = (QW > CW) ? QW : CW;
   localparam int CNTW = $clog2(LW);
   localparam int XW   = LW;
   localparam logic [CW-1:0] MAXV = {1'b0, {(CW-1){1'b1}}};

   localparam logic [1:0] PH_IDLE = 2'd0;
   localparam logic [1:0] PH_SQRT = 2'd1;
   localparam logic [1:0] PH_DIV  = 2'd2;

   logic [1:0]      phase_ff;
   logic [CNTW-1:0] cnt_ff;
   logic [2*CW-1:0] rad_ff;
   logic [CW+1:0]   rem_ff, rem_in, trial;
   logic [CW-1:0]   root_ff;
   logic [CW:0]     drem_ff, drem_in;
   logic [QW-1:0]   q_ff;
   logic            done_ff, zero_ff, nbit;
   logic [XW-1:0]   q_w;

   always_comb begin
      rem_in  = {rem_ff[CW-1:0], rad_ff[2*CW-1 -: 2]};
      trial   = {root_ff, 2'b01};
      nbit    = (cnt_ff == CNTW'(2 * FRAC_BITS));
      drem_in = {drem_ff[CW-1:0], nbit};
      q_w     = XW'(q_ff);
      inv     = (q_w > XW'(MAXV)) ? MAXV : q_w[CW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         done_ff  <= 1'b0;
      end else begin
         // pulse when the divide finishes or finds a zero root
         done_ff <= (phase_ff == PH_DIV) && ((root_ff == '0) || (cnt_ff == '0));
         case (phase_ff)
            PH_IDLE: begin
               if (start) begin
                  phase_ff <= PH_SQRT;
                  cnt_ff   <= CNTW'(CW - 1);
                  rad_ff   <= radicand;
                  rem_ff   <= '0;
                  root_ff  <= '0;
               end
            end
            PH_SQRT: begin
               rad_ff <= rad_ff << 2;
               if (rem_in >= trial) begin
                  rem_ff  <= rem_in - trial;
                  root_ff <= {root_ff[CW-2:0], 1'b1};
               end else begin
                  rem_ff  <= rem_in;
                  root_ff <= {root_ff[CW-2:0], 1'b0};
               end
               if (cnt_ff == '0) begin
                  phase_ff <= PH_DIV;
                  cnt_ff   <= CNTW'(QW - 1);
                  drem_ff  <= '0;
                  q_ff     <= '0;
               end else begin
                  cnt_ff <= cnt_ff - 1'b1;
               end
            end
            PH_DIV: begin
               if (root_ff == '0) begin
                  // zero-length normal: leave the plane as derived
                  phase_ff <= PH_IDLE;
                  zero_ff  <= 1'b1;
               end else begin
                  if (drem_in >= {1'b0, root_ff}) begin
                     drem_ff <= drem_in - {1'b0, root_ff};
                     q_ff    <= {q_ff[QW-2:0], 1'b1};
                  end else begin
                     drem_ff <= drem_in;
                     q_ff    <= {q_ff[QW-2:0], 1'b0};
                  end
                  if (cnt_ff == '0) begin
                     phase_ff <= PH_IDLE;
                     zero_ff  <= 1'b0;
                  end else begin
                     cnt_ff <= cnt_ff - 1'b1;
                  end
               end
            end
            default: begin
               phase_ff <= PH_IDLE;
            end
         endcase
      end
   end

   assign status.busy     = (phase_ff != PH_IDLE);
   assign status.done     = done_ff;
   assign status.len_zero = zero_ff;

endmodule

[rtl/frustum_plane_cull.sv]
`timescale 1ns / 1ps
// A row load is written as it is taken; a sphere or box test answers after all six planes
//   are tested (each plane: 3 issues on the shared multiplier, a drain, then 1 compare).
// A build spends most of its time in the bit-serial root and divide unit, which runs for
//   each derived plane (view mode skips it for the fixed near and far planes).
// One request is worked at a time; a new one is taken while a response waits.
// Reset (synchronous, active high) zeroes the plane chain and the configuration registers.
// ---------------------------------------------------------------------------
// frustum_plane_cull
// Six-plane frustum culling of spheres and boxes over a chain of plane cells.
// ---------------------------------------------------------------------------
`include "frustum_plane_cull_macros.svh"

module frustum_plane_cull
   import fpc_pkg::*;
#(
   parameter int COORD_WIDTH = DEF_COORD_WIDTH,
   parameter int FRAC_BITS   = DEF_FRAC_BITS
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // value_a, value_b, value_c, value_d, upper_x, upper_y, upper_z
   input  logic [223:0] req_tdata,
   // mode, row_index
   input  logic [3:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // reject_plane, zero fill
   output logic [7:0]   rsp_tdata,
   // inside_res
   output logic [0:0]   rsp_tuser,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [1:0]   csr_index,
   input  logic [31:0]  csr_data
);

   localparam int CW = COORD_WIDTH;
   localparam int PW = 2 * COORD_WIDTH;
   localparam int XW = (CW > IN_WIDTH) ? CW + 1 : IN_WIDTH + 1;
   localparam logic [CW-1:0] MAXV = {1'b0, {(CW-1){1'b1}}};
   localparam logic [CW-1:0] MINV = {1'b1, {(CW-1){1'b0}}};
   localparam logic signed [CW+1:0] MAXW = $signed({2'b00, MAXV});
   localparam logic signed [CW+1:0] MINW = $signed({2'b11, MINV});
   localparam logic signed [XW-1:0] MAXX = $signed({{(XW-CW){1'b0}}, MAXV});
   localparam logic signed [XW-1:0] MINX = $signed({{(XW-CW){1'b1}}, MINV});
   localparam logic [CW-1:0] ONE_V = (FRAC_BITS < CW - 1) ? (CW'(1) << FRAC_BITS) : MAXV;
   localparam logic [CW-1:0] NEG_ONE_V = ~ONE_V + 1'b1;

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_T_MUL  = 4'd1;
   localparam logic [3:0] S_T_WAIT = 4'd2;
   localparam logic [3:0] S_T_CMP  = 4'd3;
   localparam logic [3:0] S_T_DONE = 4'd4;
   localparam logic [3:0] S_B_DER  = 4'd5;
   localparam logic [3:0] S_B_SQ   = 4'd6;
   localparam logic [3:0] S_B_SQW  = 4'd7;
   localparam logic [3:0] S_B_ROOT = 4'd8;
   localparam logic [3:0] S_B_NRM  = 4'd9;
   localparam logic [3:0] S_B_NRMW = 4'd10;
   localparam logic [3:0] S_B_PUSH = 4'd11;

   function automatic logic [CW-1:0] sat_w(input logic signed [CW+1:0] v);
      if (v > MAXW) return MAXV;
      else if (v < MINW) return MINV;
      else return v[CW-1:0];
   endfunction

   function automatic logic [CW-1:0] sat_in(input logic [IN_WIDTH-1:0] v);
      logic signed [XW-1:0] x;
      x = $signed({{(XW-IN_WIDTH){v[IN_WIDTH-1]}}, v});
      if (x > MAXX) return MAXV;
      else if (x < MINX) return MINV;
      else return x[CW-1:0];
   endfunction

   function automatic logic signed [CW+1:0] ext(input logic [CW-1:0] v);
      return $signed({{2{v[CW-1]}}, v});
   endfunction

   // ---------------- registers
   logic                        view_ff;
   logic [CW-1:0]               near_ff, far_ff;
   logic [3:0][3:0][CW-1:0]     rows_ff;
   logic [3:0]                  state_ff;
   logic [1:0]                  mode_ff;
   logic [2:0][CW-1:0]          lo_ff, up_ff;
   logic [CW-1:0]               d_ff;
   logic [2:0]                  kc_ff, rc_ff, pidx_ff, rej_ff;
   logic signed [CW+1:0]        acc_ff;
   logic [PW-1:0]               sq_ff;
   logic [3:0][CW-1:0]          wp_ff;
   logic                        rsp_valid_ff, rsp_in_ff;
   logic [2:0]                  rsp_rej_ff;

   // ---------------- request fields
   logic [1:0]          req_mode, req_row;
   logic [6:0][CW-1:0]  req_val;

   assign req_mode = req_tuser[1:0];
   assign req_row  = req_tuser[3:2];

   always_comb begin
      for (int i = 0; i < 7; i++) begin
         req_val[i] = sat_in(req_tdata[IN_WIDTH*i +: IN_WIDTH]);
      end
   end

   // ---------------- plane chain
   logic [3:0][CW-1:0] cell_q [NUM_PLANES];
   logic [3:0][CW-1:0] head, shift_src;
   logic               shift_en;

   assign head      = cell_q[0];
   assign shift_en  = (state_ff == S_T_CMP) || (state_ff == S_B_PUSH);
   assign shift_src = (state_ff == S_B_PUSH) ? wp_ff : head;

   for (genvar g = 0; g < NUM_PLANES; g++) begin : g_cell
      logic [3:0][CW-1:0] cin;
      if (g == NUM_PLANES - 1) begin : g_tail
         assign cin = shift_src;
      end else begin : g_mid
         assign cin = cell_q[g+1];
      end
      fpc_plane_cell #(
         .COORD_WIDTH (COORD_WIDTH)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .shift_en  (shift_en),
         .plane_in  (cin),
         .plane_out (cell_q[g])
      );
   end

   // ---------------- root and divide signals
   logic          rd_start;
   rd_status_type rd_stat;
   logic [CW-1:0] rd_inv;

   // ---------------- shared multiplier
   logic          mul_issue, raw_valid, res_valid;
   logic [CW-1:0] mul_a, mul_b, mul_res;
   logic [PW-1:0] raw_prod;
   logic [2:0][CW-1:0] vert;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         vert[k] = (mode_ff == MODE_BOX && head[k][CW-1]) ? up_ff[k] : lo_ff[k];
      end
   end

   always_comb begin
      mul_issue = 1'b0;
      mul_a     = wp_ff[kc_ff[1:0]];
      mul_b     = wp_ff[kc_ff[1:0]];
      case (state_ff)
         S_T_MUL: begin
            mul_issue = 1'b1;
            mul_a     = head[kc_ff[1:0]];
            mul_b     = vert[kc_ff[1:0]];
         end
         S_B_SQ: begin
            mul_issue = 1'b1;
         end
         S_B_NRM: begin
            mul_issue = 1'b1;
            mul_b     = rd_inv;
         end
         default: begin
            mul_issue = 1'b0;
         end
      endcase
   end

   fpc_fmul #(
      .COORD_WIDTH (COORD_WIDTH),
      .FRAC_BITS   (FRAC_BITS)
   ) u_fmul (
      .clock     (clock),
      .reset     (reset),
      .issue     (mul_issue),
      .op_a      (mul_a),
      .op_b      (mul_b),
      .raw_valid (raw_valid),
      .raw_prod  (raw_prod),
      .res_valid (res_valid),
      .res       (mul_res)
   );

   // ---------------- root and divide
   assign rd_start = (state_ff == S_B_SQW) && (rc_ff == 3'd3);

   fpc_root_div #(
      .COORD_WIDTH (COORD_WIDTH),
      .FRAC_BITS   (FRAC_BITS)
   ) u_root_div (
      .clock    (clock),
      .reset    (reset),
      .start    (rd_start),
      .radicand (sq_ff),
      .status   (rd_stat),
      .inv      (rd_inv)
   );

   // ---------------- plane derivation
   logic [3:0][CW-1:0] derived;

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         case (pidx_ff)
            3'd0:    derived[k] = sat_w(-ext(rows_ff[0][k]) - ext(rows_ff[3][k]));
            3'd1:    derived[k] = sat_w(ext(rows_ff[0][k]) - ext(rows_ff[3][k]));
            3'd2:    derived[k] = sat_w(-ext(rows_ff[1][k]) - ext(rows_ff[3][k]));
            3'd3:    derived[k] = sat_w(ext(rows_ff[1][k]) - ext(rows_ff[3][k]));
            3'd4:    derived[k] = sat_w(-ext(rows_ff[2][k]));
            default: derived[k] = sat_w(ext(rows_ff[2][k]) - ext(rows_ff[3][k]));
         endcase
      end
   end

   // ---------------- plane test
   logic signed [CW+1:0] total;
   logic [CW-1:0]        dot;
   logic                 out_side;

   always_comb begin
      total = acc_ff + ext(head[3]);
      dot   = sat_w(total);
      if (mode_ff == MODE_BOX) begin
         out_side = $signed(dot) > $signed(CW'(0));
      end else begin
         out_side = $signed(d_ff) < $signed(dot);
      end
   end

   // ---------------- configuration
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         view_ff <= 1'b0;
         near_ff <= '0;
         far_ff  <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_VIEW_MODE: view_ff <= csr_data[0];
            CSR_NEAR_DIST: near_ff <= sat_in(csr_data);
            CSR_FAR_DIST:  far_ff  <= sat_in(csr_data);
            default:       view_ff <= view_ff;
         endcase
      end
   end

   // ---------------- sequencer
   assign req_tready = (state_ff == S_IDLE);

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready && req_mode == MODE_LOAD) begin
         rows_ff[req_row] <= {req_val[3], req_val[2], req_val[1], req_val[0]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_tready && state_ff != S_T_DONE) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_tvalid) begin
                  pidx_ff <= '0;
                  kc_ff   <= '0;
                  rc_ff   <= '0;
                  acc_ff  <= '0;
                  rej_ff  <= REJ_NONE;
                  mode_ff <= req_mode;
                  lo_ff   <= {req_val[2], req_val[1], req_val[0]};
                  d_ff    <= req_val[3];
                  up_ff   <= {req_val[6], req_val[5], req_val[4]};
                  if (req_mode == MODE_BUILD) begin
                     state_ff <= S_B_DER;
                  end else if (req_mode == MODE_SPHERE || req_mode == MODE_BOX) begin
                     state_ff <= S_T_MUL;
                  end
               end
            end
            S_T_MUL: begin
               kc_ff <= kc_ff + 1'b1;
               if (kc_ff == 3'd2) begin
                  state_ff <= S_T_WAIT;
               end
            end
            S_T_WAIT: begin
               if (rc_ff == 3'd3) begin
                  state_ff <= S_T_CMP;
               end
            end
            S_T_CMP: begin
               if (out_side && rej_ff == REJ_NONE) begin
                  rej_ff <= pidx_ff;
               end
               acc_ff <= '0;
               kc_ff  <= '0;
               rc_ff  <= '0;
               if (pidx_ff == 3'(NUM_PLANES - 1)) begin
                  state_ff <= S_T_DONE;
               end else begin
                  pidx_ff  <= pidx_ff + 1'b1;
                  state_ff <= S_T_MUL;
               end
            end
            S_T_DONE: begin
               // hold until the response register is free
               if (!rsp_valid_ff || rsp_tready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_rej_ff   <= rej_ff;
                  rsp_in_ff    <= (rej_ff == REJ_NONE);
                  state_ff     <= S_IDLE;
               end
            end
            S_B_DER: begin
               kc_ff <= '0;
               rc_ff <= '0;
               sq_ff <= '0;
               if (view_ff && pidx_ff == 3'd4) begin
                  wp_ff    <= {near_ff, NEG_ONE_V, CW'(0), CW'(0)};
                  state_ff <= S_B_PUSH;
               end else if (view_ff && pidx_ff == 3'd5) begin
                  wp_ff    <= {sat_w(-ext(far_ff)), ONE_V, CW'(0), CW'(0)};
                  state_ff <= S_B_PUSH;
               end else begin
                  wp_ff    <= derived;
                  state_ff <= S_B_SQ;
               end
            end
            S_B_SQ: begin
               kc_ff <= kc_ff + 1'b1;
               if (kc_ff == 3'd2) begin
                  state_ff <= S_B_SQW;
               end
            end
            S_B_SQW: begin
               if (rc_ff == 3'd3) begin
                  state_ff <= S_B_ROOT;
               end
            end
            S_B_ROOT: begin
               if (rd_stat.done) begin
                  kc_ff <= '0;
                  rc_ff <= '0;
                  state_ff <= rd_stat.len_zero ? S_B_PUSH : S_B_NRM;
               end
            end
            S_B_NRM: begin
               kc_ff <= kc_ff + 1'b1;
               if (kc_ff == 3'd3) begin
                  state_ff <= S_B_NRMW;
               end
            end
            S_B_NRMW: begin
               if (rc_ff == 3'd4) begin
                  state_ff <= S_B_PUSH;
               end
            end
            S_B_PUSH: begin
               if (pidx_ff == 3'(NUM_PLANES - 1)) begin
                  state_ff <= S_IDLE;
               end else begin
                  pidx_ff  <= pidx_ff + 1'b1;
                  state_ff <= S_B_DER;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase

         // collect multiplier results
         if ((state_ff == S_T_MUL || state_ff == S_T_WAIT) && res_valid) begin
            acc_ff <= acc_ff + ext(mul_res);
            rc_ff  <= rc_ff + 1'b1;
         end
         if ((state_ff == S_B_SQ || state_ff == S_B_SQW) && raw_valid) begin
            sq_ff <= sq_ff + raw_prod;
            rc_ff <= rc_ff + 1'b1;
         end
         if ((state_ff == S_B_NRM || state_ff == S_B_NRMW) && res_valid) begin
            wp_ff[rc_ff[1:0]] <= mul_res;
            rc_ff             <= rc_ff + 1'b1;
         end
      end
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = {5'b0, rsp_rej_ff};
   assign rsp_tuser[0] = rsp_in_ff;

   `FPC_ASSERT_IMP(a_rsp_code, clock, reset, rsp_tvalid, rsp_tuser[0] == (rsp_tdata[2:0] == REJ_NONE))
   `FPC_ASSERT_IMP(a_plane_idx, clock, reset, state_ff == S_T_CMP, pidx_ff <= 3'(NUM_PLANES - 1))
   `FPC_ASSERT_IMP(a_rd_done, clock, reset, rd_stat.done, $past(rd_stat.busy))
   `FPC_ASSERT_NXT(a_rd_start, clock, reset, rd_start, rd_stat.busy)

endmodule
